/* rtl/sorted_marker_table_nearest_assert.svh */
// Assertion macros used by the checker file of the marker table.
`ifndef SORTED_MARKER_TABLE_NEAREST_ASSERT_SVH
`define SORTED_MARKER_TABLE_NEAREST_ASSERT_SVH

// Checked only while out of reset.
`define SMTN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SMTN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/smtn_pkg.sv */
// Types and constants of the sorted marker table.
package smtn_pkg;

  localparam int unsigned MAX_MARKERS = 64;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FOUND_W  = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CUR_W    = 6;
  localparam int unsigned SAMP_W   = 36;
  localparam int unsigned RATE_W   = 21;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = TIME_W + RATE_W;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_SET    = 3'd3,
    CMD_QUERY  = 3'd4
  } smtn_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } smtn_status_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] position;
    logic [IDX_W-1:0]  entry_index;
  } smtn_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_index;
    logic [COUNT_W-1:0]  marker_count;
    logic [CUR_W-1:0]    current_index;
    logic [SAMP_W-1:0]   interval_start;
    logic [SAMP_W-1:0]   interval_end;
    logic                end_open;
  } smtn_rsp_t;

endpackage

/* rtl/smtn_scale.sv */
// Shared time-to-samples multiplier with registered product and saturation.
module smtn_scale
  import smtn_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [TIME_W-1:0] time_i,
  input  logic [RATE_W-1:0] rate_i,
  output logic [SAMP_W-1:0] samples_o
);

  logic [PROD_W-1:0]        prod_q;
  logic [PROD_W-FRAC_W-1:0] shifted;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(time_i) * PROD_W'(rate_i);
    end
  end

  assign shifted   = prod_q[PROD_W-1:FRAC_W];
  // anything past 36 bits clamps to all ones
  assign samples_o = shifted[PROD_W-FRAC_W-1:SAMP_W] != '0 ? '1 : shifted[SAMP_W-1:0];

endmodule

/* rtl/sorted_marker_table_nearest.sv */
// Sorted marker table: add, remove, nearest search, set current and current-interval report.
// Flow: query and set read the current entry and the next, scale both and emit the result;
//   add and find walk the table one entry a cycle, add and remove then shift one entry a
//   cycle, and add writes the new entry. One request at a time; busy drops in the strobe
//   cycle, so the next request can be taken there. Results are never stalled.
// The table memory has a single read port, and one multiplier serves both interval ends.
// Reset: one marker at 0, current 0, sample rate 44100; no clearing pass.
module sorted_marker_table_nearest
  import smtn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  smtn_req_t         req_i,
  output logic              done_o,
  output smtn_rsp_t         rsp_o,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i
);

  localparam int unsigned IW = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
  localparam int unsigned CW = $clog2(MAX_MARKERS + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_SHIFT = 9'b000000100,
    S_DRAIN = 9'b000001000,
    S_INS   = 9'b000010000,
    S_OUT0  = 9'b000100000,
    S_OUT1  = 9'b001000000,
    S_OUT2  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [IW-1:0]       cur_q, cur_d;
  logic [RATE_W-1:0]   rate_q, rate_d;
  logic                pend_q, pend_d;
  logic                done_q, done_d;

  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [TIME_W-1:0]   pos_q, pos_d;
  logic [CW-1:0]       p_q, p_d;
  logic [TIME_W-1:0]   prev_q, prev_d;
  logic [CW-1:0]       src_q, src_d;
  logic                up_q, up_d;
  logic [IW-1:0]       wa_q, wa_d;
  logic [IW-1:0]       found_q, found_d;
  smtn_status_e        status_q, status_d;
  logic [SAMP_W-1:0]   start_q, start_d;
  smtn_rsp_t           rsp_q, rsp_d;

  logic [TIME_W-1:0]   mem [MAX_MARKERS];
  logic [TIME_W-1:0]   rdata_q;
  logic                rzero_q;
  logic [TIME_W-1:0]   rd;
  logic [IW-1:0]       raddr;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [TIME_W-1:0]   mem_wdata;

  logic                scale_en;
  logic [SAMP_W-1:0]   samples;

  logic [XW-1:0]       idx_x, cnt_x, cur_x;
  logic [IW-1:0]       p_before;
  logic                scan_end, hit, end_open;

  // Entry 0 always holds time 0: nothing writes it and it reads as zero.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[raddr];
    rzero_q <= (raddr == '0);
  end

  assign rd        = rzero_q ? '0 : rdata_q;
  assign mem_we    = pend_q || (state_q == S_INS);
  assign mem_waddr = pend_q ? wa_q : IW'(p_q);
  assign mem_wdata = pend_q ? rd : pos_q;

  smtn_scale u_scale (
    .clk_i    (clk_i),
    .en_i     (scale_en),
    .time_i   (rd),
    .rate_i   (rate_q),
    .samples_o(samples)
  );

  assign idx_x    = XW'(req_i.entry_index);
  assign cnt_x    = XW'(cnt_q);
  assign cur_x    = XW'(cur_q);
  assign scan_end = (p_q == cnt_q) || (rd >= pos_q);
  assign hit      = (p_q != cnt_q) && (rd == pos_q);
  assign p_before = (p_q == '0) ? '0 : IW'(p_q - CW'(1));
  assign end_open = (CW'(cur_q) + CW'(1)) >= cnt_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    rate_d   = cfg_we_i ? cfg_wdata_i : rate_q;
    pend_d   = 1'b0;
    done_d   = 1'b0;
    cmd_d    = cmd_q;
    pos_d    = pos_q;
    p_d      = p_q;
    prev_d   = prev_q;
    src_d    = src_q;
    up_d     = up_q;
    wa_d     = wa_q;
    found_d  = found_q;
    status_d = status_q;
    start_d  = start_q;
    rsp_d    = rsp_q;
    raddr    = '0;
    scale_en = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d    = req_i.cmd;
          pos_d    = req_i.position;
          found_d  = '0;
          status_d = ST_DONE;
          p_d      = '0;
          prev_d   = '0;
          state_d  = S_OUT0;
          unique case (req_i.cmd)
            CMD_ADD, CMD_FIND: begin
              state_d = S_SCAN;
            end
            CMD_REMOVE: begin
              if (idx_x == '0 || idx_x == cnt_x) begin
                status_d = ST_IGNORED;
              end else if (idx_x > cnt_x) begin
                status_d = ST_BAD_INDEX;
              end else begin
                cnt_d = cnt_q - CW'(1);
                if (cur_x >= idx_x) begin
                  cur_d = cur_q - IW'(1);
                end
                if (idx_x != cnt_x - XW'(1)) begin
                  src_d   = CW'(idx_x + XW'(1));
                  up_d    = 1'b0;
                  state_d = S_SHIFT;
                end
              end
            end
            CMD_SET: begin
              if (idx_x < cnt_x) begin
                cur_d = IW'(req_i.entry_index);
              end else begin
                status_d = ST_BAD_INDEX;
              end
            end
            CMD_QUERY: begin
            end
            default: begin
              status_d = ST_IGNORED;
            end
          endcase
        end
      end

      // p_q is the entry whose data is in rd; the next read is already issued
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_OUT0;
          if (cmd_q == CMD_ADD) begin
            if (hit) begin
              status_d = ST_IGNORED;
              cur_d    = p_before;
            end else if (cnt_q == CW'(MAX_MARKERS)) begin
              status_d = ST_FULL;
            end else begin
              cur_d = p_before;
              if (p_q == cnt_q) begin
                state_d = S_INS;
              end else begin
                src_d   = cnt_q - CW'(1);
                up_d    = 1'b1;
                state_d = S_SHIFT;
              end
            end
          end else begin
            if (p_q == '0) begin
              found_d = '0;
            end else if (p_q == cnt_q) begin
              found_d = p_before;
            end else if ((rd - pos_q) < (pos_q - prev_q)) begin
              found_d = IW'(p_q);
            end else begin
              found_d = p_before;
            end
          end
        end else begin
          p_d    = p_q + CW'(1);
          prev_d = rd;
          raddr  = IW'(p_q + CW'(1));
        end
      end

      // read one entry per cycle, write it one slot over on the next cycle
      S_SHIFT: begin
        raddr  = IW'(src_q);
        pend_d = 1'b1;
        wa_d   = up_q ? IW'(src_q + CW'(1)) : IW'(src_q - CW'(1));
        // remove already decremented the count, so the last source equals it
        if (up_q ? (src_q == p_q) : (src_q == cnt_q)) begin
          state_d = S_DRAIN;
        end else begin
          src_d = up_q ? src_q - CW'(1) : src_q + CW'(1);
        end
      end

      S_DRAIN: begin
        state_d = (cmd_q == CMD_ADD) ? S_INS : S_OUT0;
      end

      S_INS: begin
        cnt_d   = cnt_q + CW'(1);
        state_d = S_OUT0;
      end

      S_OUT0: begin
        raddr   = cur_q;
        state_d = S_OUT1;
      end

      S_OUT1: begin
        scale_en = 1'b1;
        raddr    = IW'(CW'(cur_q) + CW'(1));
        state_d  = S_OUT2;
      end

      S_OUT2: begin
        start_d  = samples;
        scale_en = 1'b1;
        state_d  = S_EMIT;
      end

      S_EMIT: begin
        rsp_d.status         = status_q;
        rsp_d.found_index    = FOUND_W'(found_q);
        rsp_d.marker_count   = COUNT_W'(cnt_q);
        rsp_d.current_index  = CUR_W'(cur_q);
        rsp_d.interval_start = start_q;
        rsp_d.interval_end   = end_open ? '1 : samples;
        rsp_d.end_open       = end_open;
        done_d               = 1'b1;
        state_d              = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CW'(1);
      cur_q   <= '0;
      rate_q  <= RATE_RESET;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      rate_q  <= rate_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pos_q    <= pos_d;
    p_q      <= p_d;
    prev_q   <= prev_d;
    src_q    <= src_d;
    up_q     <= up_d;
    wa_q     <= wa_d;
    found_q  <= found_d;
    status_q <= status_d;
    start_q  <= start_d;
    rsp_q    <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* rtl/smtn_checker.sv */
// Port-level checks of the marker table and their bind to the top level.
`include "sorted_marker_table_nearest_assert.svh"

module smtn_checker
  import smtn_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input smtn_rsp_t rsp_o
);

  `SMTN_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy, "request not taken up")
  `SMTN_ASSERT(a_strobe_pulse, clk_i, rst_ni, done_o |=> !done_o, "result strobe too long")
  `SMTN_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "result while busy")
  `SMTN_ASSERT(a_open_end, clk_i, rst_ni, done_o && rsp_o.end_open |-> &rsp_o.interval_end, "open interval end not all ones")
  `SMTN_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !done_o && !busy, "activity in reset")

endmodule

bind sorted_marker_table_nearest smtn_checker u_smtn_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

/* dv/smtn_marker_checker.sv */
`timescale 1ns / 100ps
// Marker table checker: predicts each response and compares it with the block.
module smtn_marker_checker
  import smtn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  smtn_req_t         req_i,
  input  logic              done_i,
  input  smtn_rsp_t         rsp_i,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic [TIME_W-1:0] marker_q [MAX_MARKERS];
  int                count_q;
  int                cur_q;
  logic [RATE_W-1:0] rate_q;

  smtn_rsp_t rsp_due_q [$];
  smtn_rsp_t exp_rsp;
  int        fail_count;

  function automatic logic [SAMP_W-1:0] time_to_samples(input logic [TIME_W-1:0] t);
    logic [PROD_W-1:0] prod;
    prod = t * rate_q;
    // bit 52 set means the shifted product no longer fits in 36 bits
    if (prod[PROD_W-1]) return '1;
    return prod[PROD_W-2:FRAC_W];
  endfunction

  task automatic step_marker_table(input smtn_req_t r, output smtn_rsp_t e);
    int                p;
    int                found;
    int                idx;
    logic [TIME_W-1:0] d_hi;
    logic [TIME_W-1:0] d_lo;
    smtn_status_e      st;
    st    = ST_DONE;
    found = 0;
    idx   = int'(r.entry_index);
    case (r.cmd)
      CMD_ADD: begin
        p = 0;
        while (p < count_q && marker_q[p] < r.position) p++;
        if (p < count_q && marker_q[p] == r.position) begin
          st    = ST_IGNORED;
          cur_q = (p != 0) ? p - 1 : 0;
        end else if (count_q >= int'(MAX_MARKERS)) begin
          st = ST_FULL;
        end else begin
          for (int i = count_q; i > p; i--) marker_q[i] = marker_q[i-1];
          marker_q[p] = r.position;
          count_q++;
          cur_q = (p != 0) ? p - 1 : 0;
        end
      end
      CMD_REMOVE: begin
        if (idx == 0 || idx == count_q) begin
          st = ST_IGNORED;
        end else if (idx > count_q) begin
          st = ST_BAD_INDEX;
        end else begin
          for (int i = idx; i + 1 < count_q; i++) marker_q[i] = marker_q[i+1];
          count_q--;
          if (cur_q >= idx) cur_q--;
        end
      end
      CMD_FIND: begin
        for (int i = 0; i < count_q; i++) begin
          if (marker_q[i] < r.position) begin
            found = i;
          end else begin
            // first marker at or above: take it only if strictly closer
            d_hi = marker_q[i] - r.position;
            d_lo = r.position - marker_q[found];
            if (i != found && d_hi < d_lo) found = i;
            break;
          end
        end
      end
      CMD_SET: begin
        if (idx < count_q) cur_q = idx;
        else st = ST_BAD_INDEX;
      end
      CMD_QUERY: ;
      default: st = ST_IGNORED;
    endcase
    e.status         = st;
    e.found_index    = FOUND_W'(found);
    e.marker_count   = COUNT_W'(count_q);
    e.current_index  = CUR_W'(cur_q);
    e.interval_start = time_to_samples(marker_q[cur_q]);
    if (cur_q + 1 < count_q) begin
      e.interval_end = time_to_samples(marker_q[cur_q+1]);
      e.end_open     = 1'b0;
    end else begin
      e.interval_end = '1;
      e.end_open     = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_MARKERS); i++) marker_q[i] = '0;
      count_q    = 1;
      cur_q      = 0;
      rate_q     = RATE_RESET;
      fail_count = 0;
      rsp_due_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (done_i) begin
        if (rsp_due_q.size() == 0) begin
          $display("%0t: response with none outstanding, expected none, actual %0h",
                   $realtime, rsp_i);
          fail_count++;
        end else begin
          exp_rsp = rsp_due_q.pop_front();
          check_field("status", exp_rsp.status, rsp_i.status);
          check_field("found_index", exp_rsp.found_index, rsp_i.found_index);
          check_field("marker_count", exp_rsp.marker_count, rsp_i.marker_count);
          check_field("current_index", exp_rsp.current_index, rsp_i.current_index);
          check_field("interval_start", exp_rsp.interval_start, rsp_i.interval_start);
          check_field("interval_end", exp_rsp.interval_end, rsp_i.interval_end);
          check_field("end_open", exp_rsp.end_open, rsp_i.end_open);
        end
      end
      if (cfg_we_i) rate_q = cfg_wdata_i;
      if (start_i && !busy_i) begin
        step_marker_table(req_i, exp_rsp);
        rsp_due_q.push_back(exp_rsp);
      end
      pending_o    <= rsp_due_q.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

/* dv/tb_sorted_marker_table_nearest.sv */
`timescale 1ns / 100ps
// Testbench top for the sorted marker table: stimulus, clock, reset and verdict.
module tb_sorted_marker_table_nearest;
  import smtn_pkg::*;

  localparam int          CYCLE_LIMIT = 2000000;
  localparam int          PHASE_ITEMS = 220;
  localparam int          DRAIN_WAIT  = 150;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  smtn_req_t         req = '0;
  logic              done;
  smtn_rsp_t         rsp;
  logic              cfg_we = 1'b0;
  logic [RATE_W-1:0] cfg_wdata = '0;

  int  mismatch_count;
  int  rsp_pending;
  int  cycle_count = 0;
  bit  idle_en = 1'b1;

  logic [TIME_W-1:0] added_pos_q [$];

  always #4 clk_i = ~clk_i;

  sorted_marker_table_nearest i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  smtn_marker_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .rsp_i        (rsp),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (mismatch_count),
    .pending_o    (rsp_pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_req(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] p,
                          input logic [IDX_W-1:0] idx);
    smtn_req_t r;
    r.cmd         = c;
    r.position    = p;
    r.entry_index = idx;
    while (idle_en && $urandom_range(99) < 24) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    // start stays high after acceptance so back-to-back requests need no gap
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (c == CMD_ADD) begin
      added_pos_q.push_back(p);
      if (added_pos_q.size() > MAX_MARKERS) void'(added_pos_q.pop_front());
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (rsp_pending != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] v);
    wait_idle();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] pick_position();
    int r;
    r = $urandom_range(99);
    if (r < 40 || added_pos_q.size() == 0) return $urandom;
    if (r < 60) return TIME_W'($urandom_range(0, 255));
    if (r < 85) return added_pos_q[$urandom_range(0, added_pos_q.size() - 1)];
    if (r < 92) return '1;
    // near an existing marker, for close calls in the nearest search
    return added_pos_q[$urandom_range(0, added_pos_q.size() - 1)] + $urandom_range(0, 3) - 1;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(9) < 4) return IDX_W'($urandom_range(0, MAX_MARKERS));
    return IDX_W'($urandom_range(0, 15));
  endfunction

  task automatic send_random(input mix_e mix);
    int                r;
    int                add_w;
    int                rem_w;
    logic [CMD_W-1:0]  c;
    case (mix)
      MIX_FILL:  begin add_w = 65; rem_w = 10; end
      MIX_DRAIN: begin add_w = 15; rem_w = 60; end
      default:   begin add_w = 35; rem_w = 25; end
    endcase
    r = $urandom_range(99);
    if (r < add_w) c = CMD_ADD;
    else if (r < add_w + rem_w) c = CMD_REMOVE;
    else if (r < 85) c = CMD_FIND;
    else if (r < 92) c = CMD_SET;
    else if (r < 97) c = CMD_QUERY;
    else c = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    send_req(c, pick_position(), pick_index());
  endtask

  initial begin
    logic [RATE_W-1:0] rate;
    mix_e              mix;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, index edges, ties, removal around current
    send_req(CMD_QUERY, '0, '0);
    send_req(CMD_FIND, '0, '0);
    send_req(CMD_FIND, '1, '0);
    send_req(CMD_REMOVE, '0, 7'd0);
    send_req(CMD_REMOVE, '0, 7'd1);
    send_req(CMD_REMOVE, '0, 7'd64);
    send_req(CMD_SET, '0, 7'd1);
    send_req(CMD_SET, '0, 7'd0);
    send_req(CMD_ADD, '0, '0);
    send_req(CMD_ADD, '1, 7'd127);
    send_req(CMD_ADD, 32'h0000_0100, '0);
    send_req(CMD_ADD, 32'h0000_0300, '0);
    send_req(CMD_ADD, 32'h0000_0100, '0);
    send_req(CMD_FIND, 32'h0000_0200, '0);
    send_req(CMD_FIND, 32'h0000_0201, '0);
    send_req(CMD_FIND, 32'h0000_0050, '0);
    send_req(CMD_FIND, 32'hAAAA_5555, '0);
    send_req(CMD_SET, '0, 7'd2);
    send_req(CMD_REMOVE, '0, 7'd1);
    send_req(CMD_REMOVE, '0, 7'd1);
    send_req(CMD_SET, '0, 7'd2);
    send_req(CMD_REMOVE, '0, 7'd3);
    send_req(CMD_UNUSED_LO, 32'h5555_AAAA, 7'd85);
    send_req(CMD_UNUSED_HI, '0, '0);
    send_req(CMD_QUERY, '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       rate = RATE_W'(1);
        1:       rate = RATE_W'(1048576);
        2:       rate = '0;
        3:       rate = '1;
        4:       rate = RATE_W'(48000);
        5:       rate = RATE_W'($urandom_range(1, 1048576));
        6:       rate = RATE_RESET;
        default: rate = RATE_W'($urandom_range(1, 1048576));
      endcase
      case (ph % 3)
        0:       mix = MIX_FILL;
        1:       mix = MIX_BALANCED;
        default: mix = MIX_DRAIN;
      endcase
      write_rate(rate);
      idle_en = (ph != 4);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random(mix);
    end
    idle_en = 1'b1;

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/smtn_pkg.sv
rtl/smtn_scale.sv
rtl/sorted_marker_table_nearest.sv
rtl/smtn_checker.sv
dv/smtn_marker_checker.sv
dv/tb_sorted_marker_table_nearest.sv
